[hw/rtl/etrb_pkg.sv]
// Shared types, codes and constants of the event trace ring buffer.
`timescale 1ns / 1ps

package etrb_pkg;

	localparam int DEPTH_DEFAULT = 32;

	localparam logic [2:0] OP_BIND  = 3'd0;
	localparam logic [2:0] OP_TICK  = 3'd1;
	localparam logic [2:0] OP_STATE = 3'd2;
	localparam logic [2:0] OP_SEND  = 3'd3;
	localparam logic [2:0] OP_DRAIN = 3'd4;
	localparam logic [2:0] OP_RESET = 3'd5;

	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_STATE  = 2'd1;
	localparam logic [1:0] KIND_SEND   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [31:0] NO_CLIENT = 32'hFFFF_FFFF;
	localparam logic [31:0] SAT_MAX   = 32'hFFFF_FFFF;
	localparam logic [63:0] STAMP_ONE = 64'd1;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] thread_id;
		logic [31:0] event_tick;
		logic [31:0] client_id;
		logic [15:0] prev_state;
		logic [15:0] next_state;
		logic [31:0] header;
		logic [31:0] byte_count;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic        last;
		logic [1:0]  kind;
		logic [31:0] tick_out;
		logic [31:0] client_out;
		logic [31:0] states_out;
		logic [31:0] header_out;
		logic [31:0] count_out;
		logic [63:0] sequence_out;
		logic [31:0] dropped_out;
		logic [31:0] violations_out;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] tick;
		logic [31:0] client;
		logic [31:0] states;
		logic [31:0] header;
		logic [31:0] count;
		logic [63:0] sequence_no;
	} entry_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == SAT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

[hw/rtl/etrb_chan_if.sv]
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps

interface etrb_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/etrb_mem.sv]
// Event storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module etrb_mem #(
	parameter int DEPTH = etrb_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  etrb_pkg::entry_t         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output etrb_pkg::entry_t         rdata
);

	etrb_pkg::entry_t mem_q [DEPTH];
	etrb_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/etrb_ctrl.sv]
// Sequencer for binds, records and drains, with pointers, counters and the stamp.
`timescale 1ns / 1ps

module etrb_ctrl #(
	parameter int DEPTH = etrb_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_pend,
	input  etrb_pkg::req_t           req_data,
	input  logic                     out_free,
	output logic                     take,
	output logic                     load,
	output etrb_pkg::rsp_t           item,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output etrb_pkg::entry_t         mem_wdata,
	output logic                     mem_re,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  etrb_pkg::entry_t         mem_rdata
);

	localparam int IW = $clog2(DEPTH);
	localparam int PW = $clog2(DEPTH + 1);
	localparam int SW = PW + 1;

	etrb_pkg::state_t state_q, state_d;
	logic [PW-1:0] wp_q, wp_d;
	logic [IW-1:0] rp_q, rp_d;
	logic [31:0]   bound_q, bound_d;
	logic [31:0]   drop_q, drop_d;
	logic [31:0]   viol_q, viol_d;
	logic [63:0]   stamp_q, stamp_d;
	logic [PW-1:0] rem_q, rem_d;
	logic [PW-1:0] n_q, n_d;
	logic [IW-1:0] rd_addr_q, rd_addr_d;
	logic          pend_s1, pend_d;

	logic [SW-1:0] slot_sum;
	logic [SW-1:0] slot;
	logic          foreign;
	logic          mv;
	logic          issue;

	// Slot of the next free entry: read pointer plus fill, wrapped once.
	assign slot_sum  = SW'(rp_q) + SW'(wp_q);
	assign slot      = (slot_sum >= SW'(DEPTH)) ? slot_sum - SW'(DEPTH) : slot_sum;
	assign mem_waddr = slot[IW-1:0];
	assign mem_raddr = rd_addr_q;
	assign foreign   = (req_data.thread_id == 32'd0) || (bound_q == 32'd0) ||
	                   (req_data.thread_id != bound_q);

	always_comb begin
		mem_wdata             = '0;
		mem_wdata.kind        = 2'(req_data.op - etrb_pkg::OP_TICK);
		mem_wdata.tick        = req_data.event_tick;
		mem_wdata.client      = (req_data.op == etrb_pkg::OP_TICK) ?
		                        etrb_pkg::NO_CLIENT : req_data.client_id;
		mem_wdata.sequence_no = stamp_q;
		if (req_data.op == etrb_pkg::OP_STATE) begin
			mem_wdata.states = {req_data.prev_state, req_data.next_state};
		end
		if (req_data.op == etrb_pkg::OP_SEND) begin
			mem_wdata.header = req_data.header;
			mem_wdata.count  = req_data.byte_count;
		end
	end

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		bound_d   = bound_q;
		drop_d    = drop_q;
		viol_d    = viol_q;
		stamp_d   = stamp_q;
		rem_d     = rem_q;
		n_d       = n_q;
		rd_addr_d = rd_addr_q;
		pend_d    = pend_s1;
		take      = 1'b0;
		load      = 1'b0;
		item      = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mv        = 1'b0;
		issue     = 1'b0;
		unique case (state_q)
			etrb_pkg::ST_IDLE: begin
				if (req_pend && req_data.op == etrb_pkg::OP_DRAIN) begin
					take      = 1'b1;
					state_d   = etrb_pkg::ST_DRAIN;
					rem_d     = wp_q;
					n_d       = wp_q;
					rd_addr_d = rp_q;
					pend_d    = 1'b0;
				end else if (req_pend && out_free) begin
					take      = 1'b1;
					load      = 1'b1;
					item.last = 1'b1;
					item.kind = etrb_pkg::KIND_STATUS;
					unique case (req_data.op)
						etrb_pkg::OP_BIND: begin
							if (req_data.thread_id == 32'd0 ||
							    (bound_q != 32'd0 && bound_q != req_data.thread_id)) begin
								viol_d = etrb_pkg::sat_inc(viol_q);
							end else begin
								bound_d = req_data.thread_id;
								item.ok = 1'b1;
							end
						end
						etrb_pkg::OP_TICK, etrb_pkg::OP_STATE, etrb_pkg::OP_SEND: begin
							if (foreign) begin
								viol_d = etrb_pkg::sat_inc(viol_q);
							end else if (wp_q == PW'(DEPTH) || stamp_q == 64'd0) begin
								drop_d = etrb_pkg::sat_inc(drop_q);
							end else begin
								mem_we  = 1'b1;
								stamp_d = stamp_q + 64'd1;
								wp_d    = wp_q + PW'(1);
								item.ok = 1'b1;
							end
						end
						etrb_pkg::OP_RESET: begin
							wp_d    = '0;
							rp_d    = '0;
							bound_d = '0;
							drop_d  = '0;
							viol_d  = '0;
							stamp_d = etrb_pkg::STAMP_ONE;
							item.ok = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			etrb_pkg::ST_DRAIN: begin
				mv    = pend_s1 && out_free;
				issue = (rem_q != '0) && (!pend_s1 || mv);
				if (mv) begin
					load                = 1'b1;
					item.ok             = 1'b1;
					item.kind           = mem_rdata.kind;
					item.tick_out       = mem_rdata.tick;
					item.client_out     = mem_rdata.client;
					item.states_out     = mem_rdata.states;
					item.header_out     = mem_rdata.header;
					item.count_out      = mem_rdata.count;
					item.sequence_out   = mem_rdata.sequence_no;
				end
				if (issue) begin
					mem_re    = 1'b1;
					rem_d     = rem_q - PW'(1);
					rd_addr_d = (rd_addr_q == IW'(DEPTH - 1)) ? '0 : rd_addr_q + IW'(1);
				end
				pend_d = issue || (pend_s1 && !mv);
				if (rem_q == '0 && !pend_s1 && out_free) begin
					load                = 1'b1;
					item.ok             = 1'b1;
					item.last           = 1'b1;
					item.kind           = etrb_pkg::KIND_STATUS;
					item.client_out     = bound_q;
					item.count_out      = 32'(n_q);
					item.dropped_out    = drop_q;
					item.violations_out = viol_q;
					rp_d                = rd_addr_q;
					wp_d                = '0;
					state_d             = etrb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = etrb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= etrb_pkg::ST_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			bound_q   <= '0;
			drop_q    <= '0;
			viol_q    <= '0;
			stamp_q   <= etrb_pkg::STAMP_ONE;
			rem_q     <= '0;
			n_q       <= '0;
			rd_addr_q <= '0;
			pend_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			wp_q      <= wp_d;
			rp_q      <= rp_d;
			bound_q   <= bound_d;
			drop_q    <= drop_d;
			viol_q    <= viol_d;
			stamp_q   <= stamp_d;
			rem_q     <= rem_d;
			n_q       <= n_d;
			rd_addr_q <= rd_addr_d;
			pend_s1   <= pend_d;
		end
	end

	// The fill never exceeds the number of entries.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PW'(DEPTH))
		else $error("fill count above depth");

	// Events still to be read never exceed the count captured at drain start.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == etrb_pkg::ST_DRAIN |-> rem_q <= n_q)
		else $error("drain remainder above drained count");

	// Reads happen only while draining, writes only while idle and not full.
	a_read_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> state_q == etrb_pkg::ST_DRAIN)
		else $error("memory read outside a drain");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == etrb_pkg::ST_IDLE && wp_q < PW'(DEPTH))
		else $error("memory write with no room");

	// The summary empties the buffer.
	a_summary_empties: assert property (@(posedge clk) disable iff (!arst_n)
		load && item.last && state_q == etrb_pkg::ST_DRAIN |=> wp_q == '0)
		else $error("buffer not empty after drain summary");

endmodule

[hw/rtl/event_trace_ring_buffer_unit.sv]
// Top level of the event trace ring buffer: channel registers, sequencer and storage.
`timescale 1ns / 1ps

// The block takes command transactions on req (bind, record tick, record state
// change, record send attempt, drain, reset) and answers on rsp. Every command
// except a drain gives one status transaction with last set; a drain gives one
// transaction per stored event, oldest first, then a summary transaction with
// the bound producer id, the number drained and both saturating counters.
// A command is held in an input register, so req can take a transaction while
// a result still sits unclaimed in the rsp output register. Binds, records and
// resets are processed as the command is taken and, with rsp flowing, one
// command is accepted every cycle; the status appears on rsp the cycle after
// processing. A drain takes the command, then issues one read per stored event
// through the registered read port and passes each event on to rsp when its
// data returns, and finally loads the summary. The storage is read at most
// once per cycle through its single read port.
// When rsp stalls, the read pipeline holds its data and the drain pauses; the
// input register then fills and req stops accepting. Asynchronous reset and
// the reset command both clear the pointers, producer id and counters and
// restart the sequence stamp at one; the storage itself is not cleared, since
// an entry is only ever read after it has been written.

module event_trace_ring_buffer_unit #(
	parameter int DEPTH = etrb_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	etrb_chan_if.sink   req,
	etrb_chan_if.source rsp
);

	localparam int IW = $clog2(DEPTH);

	logic           req_pend_q;
	etrb_pkg::req_t req_data_q;
	logic           rsp_valid_q;
	etrb_pkg::rsp_t rsp_data_q;

	logic             out_free;
	logic             take;
	logic             load;
	etrb_pkg::rsp_t   item;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	etrb_pkg::entry_t mem_wdata;
	logic             mem_re;
	logic [IW-1:0]    mem_raddr;
	etrb_pkg::entry_t mem_rdata;

	// The output register is free when empty or when its transaction completes.
	assign out_free = !rsp_valid_q || rsp.ready;

	// A new command may enter when none is held or the held one is being consumed this cycle.
	assign req.ready = !req_pend_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_pend_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			req_pend_q <= 1'b1;
		end else if (take) begin
			req_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_data_q <= req.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_data_q <= item;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

	etrb_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_pend  (req_pend_q),
		.req_data  (req_data_q),
		.out_free  (out_free),
		.take      (take),
		.load      (load),
		.item      (item),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	etrb_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
